>>> rtl/core/tmse_pkg.sv
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared field widths, operation and register codes, halt codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tmse_pkg;

    // field widths of the item and result beats
    localparam int OP_W       = 3;
    localparam int SLOT_W     = 6;
    localparam int STATE_W    = 6;
    localparam int SYM_W      = 8;
    localparam int CELL_W     = 10;
    localparam int STEP_W     = 32;
    localparam int HALT_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD_RULE = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CELL = 3'd1;
    localparam logic [OP_W-1:0] OP_STEP      = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_CELL = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_SYMBOL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT   = 3'd3;

    // halt causes
    localparam logic [HALT_W-1:0] HALT_RUNNING = 2'd0;
    localparam logic [HALT_W-1:0] HALT_NO_RULE = 2'd1;
    localparam logic [HALT_W-1:0] HALT_LEFT    = 2'd2;
    localparam logic [HALT_W-1:0] HALT_RIGHT   = 2'd3;

    localparam logic [SYM_W-1:0] BLANK_RESET = 8'd48;

    // one rule row as stored in the rule memory
    typedef struct packed {
        logic [STATE_W-1:0] match_state;
        logic [SYM_W-1:0]   match_symbol;
        logic [SYM_W-1:0]   write_symbol;
        logic               move_right;
        logic [STATE_W-1:0] next_state;
    } t_rule;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic cfg_wr;
        logic rule_wr;
        logic restart;
        logic step_begin;
        logic fill_wr;
        logic cell_wr;
        logic sym_rd;
        logic scan_init;
        logic scan_issue;
        logic fire;
        logic no_match;
        logic res_rd;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cidx_ok;
        logic            halted;
        logic            head_oob;
        logic            fill_more;
        logic            scan_match;
        logic            scan_more;
        logic            out_free;
    } t_sts;

endpackage

>>> rtl/core/tmse_ctrl.sv
// ----------------------------------------------------------------------------
// tmse_ctrl
// Sequencer: dispatches each accepted item, runs tape growth, the rule scan
// and the result read, and hands the result beat to the output register.
// ----------------------------------------------------------------------------
module tmse_ctrl
    import tmse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_cfg_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall,
    output logic o_cfg_ready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_STEP = 4'd2;
    localparam logic [3:0] S_FILL = 4'd3;
    localparam logic [3:0] S_CELL = 4'd4;
    localparam logic [3:0] S_SYM  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_RES  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_idle;

    assign w_idle      = (r_state == S_IDLE);
    assign o_in_stall  = !w_idle;
    assign o_cfg_ready = w_idle;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.cfg_wr     = w_idle && i_cfg_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_LOAD_RULE: begin
                        o_cmd.rule_wr = 1'b1;
                        n_state       = S_RES;
                    end
                    OP_LOAD_CELL: begin
                        n_state = i_sts.cidx_ok ? S_FILL : S_RES;
                    end
                    OP_STEP: begin
                        n_state = S_STEP;
                    end
                    OP_RESTART: begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_RES;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_STEP: begin
                if (i_sts.halted) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.step_begin = 1'b1;
                    n_state          = i_sts.head_oob ? S_RES : S_FILL;
                end
            end
            // grow the tape one blank cell a cycle
            S_FILL: begin
                if (i_sts.fill_more) begin
                    o_cmd.fill_wr = 1'b1;
                end else if (i_sts.op == OP_LOAD_CELL) begin
                    n_state = S_CELL;
                end else begin
                    n_state = S_SYM;
                end
            end
            S_CELL: begin
                o_cmd.cell_wr = 1'b1;
                n_state       = S_RES;
            end
            S_SYM: begin
                o_cmd.sym_rd    = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            // one rule row read and one compared each cycle
            S_SCAN: begin
                priority if (i_sts.scan_match) begin
                    o_cmd.fire = 1'b1;
                    n_state    = S_RES;
                end else if (i_sts.scan_more) begin
                    o_cmd.scan_issue = 1'b1;
                end else begin
                    o_cmd.no_match = 1'b1;
                    n_state        = S_RES;
                end
            end
            S_RES: begin
                o_cmd.res_rd = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/tmse_dpath.sv
// ----------------------------------------------------------------------------
// tmse_dpath
// Datapath: item capture, configuration registers, rule and tape memories,
// machine registers and the output register.
// ----------------------------------------------------------------------------
module tmse_dpath
    import tmse_pkg::*;
#(
    parameter int RULE_DEPTH = 64,
    parameter int TAPE_DEPTH = 1024
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [SLOT_W-1:0]     i_rule_slot,
    input  logic [STATE_W-1:0]    i_rule_state,
    input  logic [SYM_W-1:0]      i_rule_symbol,
    input  logic [SYM_W-1:0]      i_rule_write_symbol,
    input  logic                  i_rule_move_right,
    input  logic [STATE_W-1:0]    i_rule_next_state,
    input  logic [CELL_W-1:0]     i_cell_index,
    input  logic [SYM_W-1:0]      i_cell_value,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [STATE_W-1:0]    o_machine_state,
    output logic [CELL_W-1:0]     o_head_position,
    output logic [SYM_W-1:0]      o_cell_symbol,
    output logic [STEP_W-1:0]     o_steps_taken,
    output logic                  o_rule_applied,
    output logic [HALT_W-1:0]     o_halt_cause
);

    localparam int RW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CW = $clog2(RULE_DEPTH + 1);
    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int HW = (TAPE_DEPTH > 1024) ? $clog2(TAPE_DEPTH) : CELL_W;
    localparam int LW = $clog2(TAPE_DEPTH + 1);
    localparam logic [31:0] RULE_LIMIT = 32'(RULE_DEPTH);
    localparam logic [31:0] TAPE_LIMIT = 32'(TAPE_DEPTH);

    // captured item
    logic [OP_W-1:0]    r_op;
    logic [SLOT_W-1:0]  r_slot;
    t_rule              r_new_rule;
    logic [CELL_W-1:0]  r_cidx;
    logic [SYM_W-1:0]   r_cval;

    // configuration
    logic [STATE_W-1:0] r_start_state;
    logic [SYM_W-1:0]   r_blank;
    logic [CELL_W-1:0]  r_start_head;
    logic [COUNT_W-1:0] r_rule_count;

    // machine
    logic [LW-1:0]      r_len;
    logic [HW-1:0]      r_head;
    logic [STATE_W-1:0] r_cur;
    logic [STEP_W-1:0]  r_steps;
    logic [HALT_W-1:0]  r_halt;
    logic               r_fired;

    // rule scan
    logic [CW-1:0]      r_idx;
    logic               r_scan_v;
    t_rule              r_row;

    // memories and read registers
    t_rule              rule_mem [RULE_DEPTH];
    logic [SYM_W-1:0]   tape_mem [TAPE_DEPTH];
    logic [SYM_W-1:0]   r_tape_q;
    logic               r_inrange;

    // output register
    logic               r_out_valid;
    logic [STATE_W-1:0] r_out_state;
    logic [CELL_W-1:0]  r_out_head;
    logic [SYM_W-1:0]   r_out_sym;
    logic [STEP_W-1:0]  r_out_steps;
    logic               r_out_fired;
    logic [HALT_W-1:0]  r_out_halt;

    logic [31:0]        w_head32;
    logic [31:0]        w_head_inc32;
    logic [31:0]        w_cidx32;
    logic [31:0]        w_slot32;
    logic [31:0]        w_len32;
    logic [31:0]        w_idx32;
    logic [31:0]        w_rc32;
    logic [31:0]        w_pos32;
    logic [31:0]        w_res32;
    logic [31:0]        w_start_head32;

    logic               w_tape_we;
    logic [AW-1:0]      w_tape_waddr;
    logic [SYM_W-1:0]   w_tape_wdata;
    logic               w_tape_re;
    logic [AW-1:0]      w_tape_raddr;

    // widened views for compares
    assign w_head32       = 32'(r_head);
    assign w_head_inc32   = w_head32 + 32'd1;
    assign w_cidx32       = 32'(r_cidx);
    assign w_slot32       = 32'(r_slot);
    assign w_len32        = 32'(r_len);
    assign w_idx32        = 32'(r_idx);
    assign w_rc32         = 32'(r_rule_count);
    assign w_start_head32 = 32'(r_start_head);
    assign w_pos32        = (r_op == OP_LOAD_CELL) ? w_cidx32 : w_head32;
    assign w_res32        = (r_op == OP_READ_CELL) ? w_cidx32 : w_head32;

    // status to the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.cidx_ok    = (w_cidx32 < TAPE_LIMIT);
        o_sts.halted     = (r_halt != HALT_RUNNING);
        o_sts.head_oob   = (w_head32 >= TAPE_LIMIT);
        o_sts.fill_more  = (w_len32 <= w_pos32);
        o_sts.scan_match = r_scan_v && (r_row.match_state == r_cur)
                           && (r_row.match_symbol == r_tape_q);
        o_sts.scan_more  = (w_idx32 < w_rc32) && (w_idx32 < RULE_LIMIT);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op                    <= i_operation;
            r_slot                  <= i_rule_slot;
            r_new_rule.match_state  <= i_rule_state;
            r_new_rule.match_symbol <= i_rule_symbol;
            r_new_rule.write_symbol <= i_rule_write_symbol;
            r_new_rule.move_right   <= i_rule_move_right;
            r_new_rule.next_state   <= i_rule_next_state;
            r_cidx                  <= i_cell_index;
            r_cval                  <= i_cell_value;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_blank       <= BLANK_RESET;
            r_start_head  <= '0;
            r_rule_count  <= '0;
        end else if (i_cmd.cfg_wr) begin
            unique case (i_cfg_index)
                CFG_START_STATE:  r_start_state <= i_cfg_data[STATE_W-1:0];
                CFG_BLANK_SYMBOL: r_blank       <= i_cfg_data[SYM_W-1:0];
                CFG_START_HEAD:   r_start_head  <= i_cfg_data[CELL_W-1:0];
                CFG_RULE_COUNT:   r_rule_count  <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // rule memory: write on load rule, registered read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.rule_wr && (w_slot32 < RULE_LIMIT)) begin
            rule_mem[w_slot32[RW-1:0]] <= r_new_rule;
        end
        if (i_cmd.scan_issue) begin
            r_row <= rule_mem[w_idx32[RW-1:0]];
        end
    end

    // scan index and row-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_v <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_scan_v <= i_cmd.scan_issue;
            if (i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.scan_issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // tape write and read port selection
    always_comb begin
        w_tape_we    = i_cmd.fill_wr || i_cmd.cell_wr || i_cmd.fire;
        w_tape_waddr = w_head32[AW-1:0];
        w_tape_wdata = r_row.write_symbol;
        priority if (i_cmd.fill_wr) begin
            w_tape_waddr = w_len32[AW-1:0];
            w_tape_wdata = r_blank;
        end else if (i_cmd.cell_wr) begin
            w_tape_waddr = w_cidx32[AW-1:0];
            w_tape_wdata = r_cval;
        end else begin
            w_tape_waddr = w_head32[AW-1:0];
            w_tape_wdata = r_row.write_symbol;
        end
        w_tape_re    = i_cmd.sym_rd || i_cmd.res_rd;
        w_tape_raddr = i_cmd.sym_rd ? w_head32[AW-1:0] : w_res32[AW-1:0];
    end

    // tape memory
    always_ff @(posedge i_clk) begin
        if (w_tape_we) begin
            tape_mem[w_tape_waddr] <= w_tape_wdata;
        end
        if (w_tape_re) begin
            r_tape_q <= tape_mem[w_tape_raddr];
        end
    end

    // cell under the result address is written tape
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_rd) begin
            r_inrange <= (w_res32 < TAPE_LIMIT) && (w_res32 < w_len32);
        end
    end

    // rule-applied flag of the current item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_fired <= 1'b0;
        end else if (i_cmd.fire) begin
            r_fired <= 1'b1;
        end
    end

    // machine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_head  <= '0;
            r_cur   <= '0;
            r_steps <= '0;
            r_halt  <= HALT_RUNNING;
        end else begin
            if (i_cmd.restart) begin
                r_cur   <= r_start_state;
                r_head  <= w_start_head32[HW-1:0];
                r_steps <= '0;
                r_halt  <= HALT_RUNNING;
            end
            if (i_cmd.step_begin) begin
                if (r_steps != '1) begin
                    r_steps <= r_steps + 1'b1;
                end
                if (w_head32 >= TAPE_LIMIT) begin
                    r_halt <= HALT_RIGHT;
                end
            end
            if (i_cmd.fill_wr) begin
                r_len <= r_len + 1'b1;
            end
            if (i_cmd.no_match) begin
                r_halt <= HALT_NO_RULE;
            end
            // fired rule: next state and head move with edge checks
            if (i_cmd.fire) begin
                r_cur <= r_row.next_state;
                if (r_row.move_right) begin
                    if (w_head_inc32 >= TAPE_LIMIT) begin
                        r_halt <= HALT_RIGHT;
                    end else begin
                        r_head <= r_head + 1'b1;
                    end
                end else begin
                    if (r_head == '0) begin
                        r_halt <= HALT_LEFT;
                    end else begin
                        r_head <= r_head - 1'b1;
                    end
                end
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_state <= r_cur;
            r_out_head  <= w_head32[CELL_W-1:0];
            r_out_sym   <= r_inrange ? r_tape_q : r_blank;
            r_out_steps <= r_steps;
            r_out_fired <= r_fired;
            r_out_halt  <= r_halt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_machine_state = r_out_state;
    assign o_head_position = r_out_head;
    assign o_cell_symbol   = r_out_sym;
    assign o_steps_taken   = r_out_steps;
    assign o_rule_applied  = r_out_fired;
    assign o_halt_cause    = r_out_halt;

endmodule

>>> rtl/core/turing_machine_step_engine_core.sv
// ----------------------------------------------------------------------------
// turing_machine_step_engine_core
// Single-tape Turing machine: rule and tape loading, single steps, cell reads
// and restart, one result beat per item.
// ----------------------------------------------------------------------------
// One item is taken at a time. Load rule, read cell, restart and unknown codes
// go from dispatch straight to the result read. Load cell grows the tape as
// needed, filling the gap with blanks one tape-memory write a cycle. A step
// grows the tape up to the head the same way, then scans rule rows (up to
// rule_count, bounded by RULE_DEPTH): the rule memory gives one row a cycle
// to the match compare. A step while halted goes straight to the result read.
// No clearing pass follows reset: the tape length register marks which cells
// hold data. The next item is accepted while the previous result beat still
// waits in the output register.
module turing_machine_step_engine_core
    import tmse_pkg::*;
#(
    parameter int RULE_DEPTH = 64,
    parameter int TAPE_DEPTH = 1024
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [SLOT_W-1:0]     i_rule_slot,
    input  logic [STATE_W-1:0]    i_rule_state,
    input  logic [SYM_W-1:0]      i_rule_symbol,
    input  logic [SYM_W-1:0]      i_rule_write_symbol,
    input  logic                  i_rule_move_right,
    input  logic [STATE_W-1:0]    i_rule_next_state,
    input  logic [CELL_W-1:0]     i_cell_index,
    input  logic [SYM_W-1:0]      i_cell_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATE_W-1:0]    o_machine_state,
    output logic [CELL_W-1:0]     o_head_position,
    output logic [SYM_W-1:0]      o_cell_symbol,
    output logic [STEP_W-1:0]     o_steps_taken,
    output logic                  o_rule_applied,
    output logic [HALT_W-1:0]     o_halt_cause,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    tmse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // storage and arithmetic
    tmse_dpath #(
        .RULE_DEPTH (RULE_DEPTH),
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_operation         (i_operation),
        .i_rule_slot         (i_rule_slot),
        .i_rule_state        (i_rule_state),
        .i_rule_symbol       (i_rule_symbol),
        .i_rule_write_symbol (i_rule_write_symbol),
        .i_rule_move_right   (i_rule_move_right),
        .i_rule_next_state   (i_rule_next_state),
        .i_cell_index        (i_cell_index),
        .i_cell_value        (i_cell_value),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_machine_state     (o_machine_state),
        .o_head_position     (o_head_position),
        .o_cell_symbol       (o_cell_symbol),
        .o_steps_taken       (o_steps_taken),
        .o_rule_applied      (o_rule_applied),
        .o_halt_cause        (o_halt_cause)
    );

endmodule

>>> rtl/core/tmse_checker.sv
// ----------------------------------------------------------------------------
// tmse_checker
// Port-level checks of the step engine, bound to the top level.
// ----------------------------------------------------------------------------
module tmse_checker
    import tmse_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [STATE_W-1:0] o_machine_state,
    input logic [CELL_W-1:0]  o_head_position,
    input logic [SYM_W-1:0]   o_cell_symbol,
    input logic [STEP_W-1:0]  o_steps_taken,
    input logic               o_rule_applied,
    input logic [HALT_W-1:0]  o_halt_cause
);

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable({o_machine_state, o_head_position,
            o_cell_symbol, o_steps_taken, o_rule_applied, o_halt_cause}))
        else $error("result payload changed while stalled");

    // one item at a time: accepting a beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    // a fired rule never reports a no-match halt and counts as an attempt
    a_fired_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rule_applied |->
            (o_halt_cause != HALT_NO_RULE) && (o_steps_taken != '0))
        else $error("fired rule with no-match halt or zero step count");

endmodule

bind turing_machine_step_engine_core tmse_checker u_tmse_checker (.*);
